// File: rtl/core/assert_macros.svh
// ============================================================================
// assert_macros.svh - concurrent assertion helpers
// Implication checks clocked on a rising edge, disabled while in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/gasd_pkg.sv
// ============================================================================
// gasd_pkg - shared types and constants
// Item structs and the e^(-j/64) fraction table for the decoder.
// ============================================================================
package gasd_pkg;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               first_of_sequence;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  token;
        logic        token_valid;
        logic [15:0] token_probability;
        logic [15:0] mean_confidence;
        logic [6:0]  char_count;
        logic        last;
    } t_out_item;

    localparam logic [15:0] RST_CLASS_COUNT  = 16'd127;
    localparam logic [15:0] RST_SEQ_STEPS    = 16'd33;
    localparam logic [23:0] ONE_Q16          = 24'd65536;
    localparam logic [30:0] EXP_M1_Q32       = 31'd1580030169;
    localparam logic [10:0] EXP_K_MAX        = 11'd1024;
    localparam int          DIV_W            = 33;

    typedef logic [32:0] t_frac_tab [64];

    // Taylor series of e^(-j/64) in Q1.32, truncating per term
    function automatic t_frac_tab build_exp_frac();
        t_frac_tab   tab;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        for (int j = 0; j < 64; j++) begin
            x    = 64'(j) << 26;
            term = 64'd1 << 32;
            pos  = term;
            neg  = 64'd0;
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x) >> 32) / 64'(n);
                if ((n % 2) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            tab[j] = 33'(pos - neg);
        end
        return tab;
    endfunction

    localparam t_frac_tab EXP_FRAC = build_exp_frac();

endpackage

// File: rtl/core/greedy_argmax_softmax_decoder.sv
// Sequencing: the first logit of a row goes straight to the row-end check; any other logit runs
//   one e^-1 multiply per whole unit of difference to the row maximum (up to 16), then the update.
// A row-closing logit adds a reciprocal division, a mean division (skipped while no character
//   has been emitted) and the load of the result register, which waits for a free output.
// Throughput: one item at a time; ready stays low until the sequencer is idle again.
// Reset: synchronous active-low; registers return to 127 classes, 33 steps.
// ============================================================================
// greedy_argmax_softmax_decoder - greedy argmax decoder with softmax confidence
// Sequencer around an e^-1 scaling multiplier, a sum rescale multiplier and one iterative divider.
// ============================================================================
module greedy_argmax_softmax_decoder #(
    parameter int MAX_CLASSES = 128,
    parameter int MAX_STEPS   = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gasd_pkg::t_in_item   i_in,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gasd_pkg::t_out_item  o_out,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import gasd_pkg::*;

    localparam int PW = $clog2(MAX_CLASSES + 1);  // class position / count
    localparam int SW = $clog2(MAX_STEPS + 1);    // step position / count

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXPM = 3'd1;   // repeated e^-1 scaling
    localparam logic [2:0] S_UPD  = 3'd2;   // max / sum update
    localparam logic [2:0] S_ROW  = 3'd3;   // row end check
    localparam logic [2:0] S_DIVP = 3'd4;   // reciprocal of sum
    localparam logic [2:0] S_DIVM = 3'd5;   // mean confidence
    localparam logic [2:0] S_EMIT = 3'd6;   // hand result to output register

    localparam logic REG_CLASS = 1'b0;
    localparam logic REG_STEPS = 1'b1;

    logic [2:0]         r_st, n_st;
    logic [7:0]         r_cc;
    logic [6:0]         r_ns;
    logic signed [15:0] r_x;
    logic               r_gt;
    logic [PW-1:0]      r_pos, n_pos;
    logic [SW-1:0]      r_step, n_step;
    logic signed [15:0] r_max, n_max;
    logic [PW-1:0]      r_best, n_best;
    logic [23:0]        r_sum, n_sum;
    logic [21:0]        r_conf, n_conf;
    logic [SW-1:0]      r_emit, n_emit;
    logic               r_done, n_done;
    logic [4:0]         r_i;
    logic [32:0]        r_v;
    logic [16:0]        r_e;
    logic [15:0]        r_prob;
    logic [15:0]        r_mean;
    logic               r_eos;
    logic               r_final;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [PW-1:0]      w_cc;     // effective class count
    logic [SW-1:0]      w_ns;     // effective step count
    logic               w_acc;
    logic               w_cfg_wr;
    logic               w_fos;
    logic signed [16:0] w_diff;
    logic [16:0]        w_mag;
    logic [10:0]        w_k;
    logic [63:0]        w_expm;
    logic [40:0]        w_resc;
    logic [32:0]        w_vr;
    logic               w_div_start;
    logic [DIV_W-1:0]   w_div_dvd;
    logic [23:0]        w_div_dvs;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_div_q;
    logic [15:0]        w_prob;
    logic               w_eos;
    logic [21:0]        w_conf_new;
    logic [SW-1:0]      w_emit_new;
    logic               w_out_free;

    // ---------------------------------------------------------------- config
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_CLASS) ? {24'd0, r_cc} : {25'd0, r_ns};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= RST_CLASS_COUNT[7:0];
            r_ns <= RST_SEQ_STEPS[6:0];
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_CLASS: r_cc <= pwdata[7:0];
                REG_STEPS: r_ns <= pwdata[6:0];
                default:   r_cc <= r_cc;
            endcase
        end
    end

    // clamp counts into their legal ranges
    always_comb begin
        if (r_cc < 8'd2) begin
            w_cc = PW'(2);
        end else if (32'(r_cc) > 32'(MAX_CLASSES)) begin
            w_cc = PW'(MAX_CLASSES);
        end else begin
            w_cc = PW'(r_cc);
        end
        if (r_ns == 7'd0) begin
            w_ns = SW'(1);
        end else if (32'(r_ns) > 32'(MAX_STEPS)) begin
            w_ns = SW'(MAX_STEPS);
        end else begin
            w_ns = SW'(r_ns);
        end
    end

    // ---------------------------------------------------------------- datapath
    assign o_in_ready = (r_st == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_fos      = i_in.first_of_sequence;

    // magnitude of the difference against the current row maximum
    assign w_diff = 17'(i_in.logit) - 17'(r_max);
    assign w_mag  = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);
    assign w_k    = (w_mag[16:4] > 13'(EXP_K_MAX)) ? EXP_K_MAX : w_mag[14:4];

    // multipliers: e^-1 scaling, then the sum rescale
    assign w_expm = 64'(r_v) * 64'(EXP_M1_Q32) + (64'd1 << 31);
    assign w_resc = 41'(r_sum) * 41'(r_e);
    assign w_vr   = r_v + 33'd32768;

    // saturated reciprocal straight off the divider
    assign w_prob     = (w_div_q > DIV_W'(65535)) ? 16'hFFFF : w_div_q[15:0];
    assign w_eos      = (r_best >= w_cc - 1'b1);
    assign w_conf_new = w_eos ? r_conf : r_conf + 22'(w_prob);
    assign w_emit_new = w_eos ? r_emit : r_emit + 1'b1;
    assign w_out_free = !r_out_valid || i_out_ready;

    // divider operands: 2^32 / sum at row end, then conf / count
    always_comb begin
        w_div_start = 1'b0;
        w_div_dvd   = {1'b1, 32'd0};
        w_div_dvs   = r_sum;
        if (r_st == S_ROW && r_pos + 1'b1 >= w_cc && !r_done) begin
            w_div_start = 1'b1;
        end else if (r_st == S_DIVP && w_div_done && w_emit_new != '0) begin
            w_div_start = 1'b1;
            w_div_dvd   = DIV_W'(w_conf_new);
            w_div_dvs   = 24'(w_emit_new);
        end
    end

    gasd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_st   = r_st;
        n_pos  = r_pos;
        n_step = r_step;
        n_max  = r_max;
        n_best = r_best;
        n_sum  = r_sum;
        n_conf = r_conf;
        n_emit = r_emit;
        n_done = r_done;
        case (r_st)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_fos) begin
                        n_pos  = '0;
                        n_step = '0;
                        n_conf = '0;
                        n_emit = '0;
                        n_done = 1'b0;
                    end
                    if (w_fos || r_pos == '0) begin
                        n_max  = i_in.logit;
                        n_best = '0;
                        n_sum  = ONE_Q16;
                        n_st   = S_ROW;
                    end else begin
                        n_st = S_EXPM;
                    end
                end
            end
            S_EXPM: begin
                if (r_i == 5'd0) begin
                    n_st = S_UPD;
                end
            end
            S_UPD: begin
                if (r_gt) begin
                    n_sum  = w_resc[39:16] + ONE_Q16;
                    n_max  = r_x;
                    n_best = r_pos;
                end else begin
                    n_sum = r_sum + 24'(r_e);
                end
                n_st = S_ROW;
            end
            S_ROW: begin
                if (r_pos + 1'b1 < w_cc) begin
                    n_pos = r_pos + 1'b1;
                    n_st  = S_IDLE;
                end else begin
                    n_pos = '0;
                    if (r_done) begin
                        if (r_step + 1'b1 >= w_ns) begin
                            n_step = '0;
                            n_conf = '0;
                            n_emit = '0;
                            n_done = 1'b0;
                        end else begin
                            n_step = r_step + 1'b1;
                        end
                        n_st = S_IDLE;
                    end else begin
                        n_st = S_DIVP;
                    end
                end
            end
            S_DIVP: begin
                if (w_div_done) begin
                    n_conf = w_conf_new;
                    n_emit = w_emit_new;
                    n_st   = (w_emit_new != '0) ? S_DIVM : S_EMIT;
                end
            end
            S_DIVM: begin
                if (w_div_done) begin
                    n_st = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    if (r_final) begin
                        n_step = '0;
                        n_conf = '0;
                        n_emit = '0;
                        n_done = 1'b0;
                    end else begin
                        n_step = r_step + 1'b1;
                        n_done = r_done || r_eos;
                    end
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_pos       <= '0;
            r_step      <= '0;
            r_max       <= '0;
            r_best      <= '0;
            r_sum       <= '0;
            r_conf      <= '0;
            r_emit      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_pos  <= n_pos;
            r_step <= n_step;
            r_max  <= n_max;
            r_best <= n_best;
            r_sum  <= n_sum;
            r_conf <= n_conf;
            r_emit <= n_emit;
            r_done <= n_done;
            if (r_st == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_x  <= i_in.logit;
            r_gt <= !w_diff[16] && w_diff != 17'sd0;
            r_i  <= w_k[10:6];
            r_v  <= EXP_FRAC[w_k[5:0]];
        end
        if (r_st == S_EXPM) begin
            if (r_i != 5'd0) begin
                r_v <= w_expm[64-1:32] & 33'h1_FFFF_FFFF;
                r_i <= r_i - 1'b1;
            end else begin
                r_e <= w_vr[32:16];
            end
        end
        if (r_st == S_ROW) begin
            r_final <= (r_step + 1'b1 >= w_ns);
        end
        if (r_st == S_DIVP && w_div_done) begin
            r_prob <= w_prob;
            r_eos  <= w_eos;
            r_mean <= 16'd0;
        end
        if (r_st == S_DIVM && w_div_done) begin
            r_mean <= w_div_q[15:0];
        end
        if (r_st == S_EMIT && w_out_free) begin
            r_out.token             <= 7'(r_best);
            r_out.token_valid       <= !r_eos;
            r_out.token_probability <= r_prob;
            r_out.mean_confidence   <= r_mean;
            r_out.char_count        <= 7'(r_emit);
            r_out.last              <= r_eos || r_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/core/gasd_div.sv
// ============================================================================
// gasd_div - iterative restoring divider
// One quotient bit per cycle; done pulses with the quotient.
// ============================================================================
module gasd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gasd_pkg::DIV_W-1:0] i_dividend,
    input  logic [23:0]               i_divisor,
    output logic                      o_done,
    output logic [gasd_pkg::DIV_W-1:0] o_quotient
);
    import gasd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [23:0]      r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [23:0]      r_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [24:0]      w_sh;
    logic [24:0]      w_trial;

    assign w_sh    = {r_rem, r_quo[DIV_W-1]};
    assign w_trial = w_sh - {1'b0, r_dvs};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_rem = 24'd0;
            n_quo = i_dividend;
            n_cnt = CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            if (!w_trial[24]) begin
                n_rem = w_trial[23:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh[23:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/core/gasd_chk.sv
// ============================================================================
// gasd_chk - port-level checks for the decoder
// Watches the top-level ports only; bound into the top level.
// ============================================================================
`include "assert_macros.svh"

module gasd_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input gasd_pkg::t_out_item o_out,
    input logic                pready
);
    import gasd_pkg::*;

    `AST_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)
    `AST_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))
    `AST_NXT(a_busy_after_acc, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `AST_IMP(a_eos_last, i_clk, i_rst_n, o_out_valid && !o_out.token_valid, o_out.last)
    `AST_IMP(a_mean_empty, i_clk, i_rst_n, o_out_valid && o_out.char_count == 7'd0, o_out.mean_confidence == 16'd0)

endmodule

bind greedy_argmax_softmax_decoder gasd_chk u_gasd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .pready      (pready)
);

// File: tb/sv/tb_greedy_argmax_softmax_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_greedy_argmax_softmax_decoder - self-checking bench for the greedy decoder
// Streams logit rows through the decoder under several class/step settings and
// idle patterns. Every result is checked against an in-bench decoder model or one given by hand.
// ============================================================================
module tb_greedy_argmax_softmax_decoder;
    import gasd_pkg::*;

    localparam int  LIMIT       = 1000000;
    localparam int  SETTLE      = 120;      // > reciprocal + mean division + exp steps
    localparam int  EXP_M1      = 1580030169;
    localparam logic [2:0] ADDR_CLASSES = 3'd0;
    localparam logic [2:0] ADDR_STEPS   = 3'd4;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic signed [15:0] lg;
        bit                 fs;
        bit                 typed;      // expected result given by hand
        t_out_item          res;
    } t_row;

    typedef struct {
        int         classes;
        int         steps;
        int         items;
        t_idle_mode mode;
    } t_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    greedy_argmax_softmax_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decoder model state: raw register copies plus the row/sequence trackers
    // ------------------------------------------------------------------------
    int unsigned cfg_classes = 127;
    int unsigned cfg_steps   = 33;
    int unsigned m_class_pos, m_step_pos, m_best, m_exp_sum, m_conf_sum, m_chars;
    int          m_row_max;
    bit          m_seq_done;

    t_out_item   pending_tokens[$];
    t_idle_mode  idle_mode = IDLE_NONE;
    int          mismatches = 0;
    int          cycles = 0;

    // e^(-mag/1024) in Q1.16: 1/64 steps, truncated, clamped at -16
    function automatic logic [16:0] exp_neg(input int unsigned mag);
        int unsigned k, whole, frac;
        logic [63:0] x, term, pos, neg, v;
        k = mag >> 4;
        if (k > 1024) k = 1024;
        whole = k >> 6;
        frac  = k & 63;
        x     = 64'(frac) << 26;
        term  = 64'd1 << 32;
        pos   = term;
        neg   = 64'd0;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x) >> 32) / 64'(n);
            if (n % 2 == 1) neg += term;
            else pos += term;
        end
        v = pos - neg;
        for (int n = 0; n < whole; n++) v = (v * 64'(EXP_M1) + (64'd1 << 31)) >> 32;
        return 17'((v + 64'd32768) >> 16);
    endfunction

    function automatic void restart_sequence();
        m_step_pos = 0;
        m_conf_sum = 0;
        m_chars    = 0;
        m_seq_done = 1'b0;
    endfunction

    // Consume one logit; got=1 when the row closes with a token to emit
    task automatic decode_logit(input t_in_item it, output bit got, output t_out_item tok);
        int          x;
        int unsigned cc, ns, prob, mean;
        bit          fin, eos_hit;
        logic [63:0] scaled;
        x   = int'(it.logit);
        cc  = cfg_classes;
        ns  = cfg_steps;
        got = 1'b0;
        tok = '0;
        if (cc < 2) cc = 2;
        if (cc > 128) cc = 128;
        if (ns < 1) ns = 1;
        if (ns > 64) ns = 64;
        if (it.first_of_sequence) begin
            m_class_pos = 0;
            restart_sequence();
        end
        if (m_class_pos == 0) begin
            m_row_max = x;
            m_best    = 0;
            m_exp_sum = 65536;
        end else if (x > m_row_max) begin
            // new maximum: rescale the running sum, add one for the new leader
            scaled    = 64'(m_exp_sum) * 64'(exp_neg(x - m_row_max));
            m_exp_sum = 32'(scaled >> 16) + 65536;
            m_row_max = x;
            m_best    = m_class_pos;
        end else begin
            m_exp_sum += exp_neg(m_row_max - x);
        end
        m_exp_sum &= 32'hFFFFFF;
        if (m_class_pos + 1 < cc) begin
            m_class_pos++;
            return;
        end
        m_class_pos = 0;
        fin = (m_step_pos + 1 >= ns);
        if (m_seq_done) begin
            // rows after end of sequence are swallowed
            if (fin) restart_sequence();
            else m_step_pos++;
            return;
        end
        prob = (m_exp_sum != 0) ? 32'((64'd1 << 32) / 64'(m_exp_sum)) : 0;
        if (prob > 65535) prob = 65535;
        eos_hit = (m_best >= cc - 1);
        if (!eos_hit) begin
            m_conf_sum += prob;
            m_chars++;
        end
        mean = (m_chars != 0) ? m_conf_sum / m_chars : 0;
        tok.token             = 7'(m_best);
        tok.token_valid       = !eos_hit;
        tok.token_probability = 16'(prob);
        tok.mean_confidence   = 16'(mean);
        tok.char_count        = 7'(m_chars);
        tok.last              = eos_hit || fin;
        got = 1'b1;
        if (eos_hit) m_seq_done = 1'b1;
        if (fin) restart_sequence();
        else m_step_pos++;
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_logit(input t_in_item it, input bit typed, input t_out_item hand);
        bit        got;
        t_out_item tok;
        int        idle_pct;
        idle_pct = (idle_mode == IDLE_BOTH) ? 6 : 83;
        if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
            while ($urandom_range(99) < idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        decode_logit(it, got, tok);
        if (got) pending_tokens.insert(pending_tokens.size(), typed ? hand : tok);
    endtask

    task automatic reg_write(input logic [2:0] addr, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);   // register takes the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CLASSES) cfg_classes = value & 8'hFF;
        else cfg_steps = value & 7'h7F;
    endtask

    // wait until every token is back, then let a row-closing tail finish
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_logit();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return 16'($urandom_range(128)) - 16'd64;  // ties, small gaps
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_tokens.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected token item %p", o_out);
            end else begin
                want = pending_tokens.pop_front();
                if (o_out.token !== want.token
                        || o_out.token_valid !== want.token_valid
                        || o_out.token_probability !== want.token_probability
                        || o_out.mean_confidence !== want.mean_confidence
                        || o_out.char_count !== want.char_count
                        || o_out.last !== want.last) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("token mismatch: exp %p got %p", want, o_out);
                end
            end
        end
        if (idle_mode == IDLE_RECEIVER)
            i_out_ready <= ($urandom_range(99) >= 83);
        else if (idle_mode == IDLE_BOTH)
            i_out_ready <= ($urandom_range(99) >= 6);
        else
            i_out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    t_row   rows[17];
    t_phase phases[7];

    initial begin
        t_in_item it;
        bit       seq_start;

        // directed rows, 2 classes x 3 steps
        rows[0]  = '{16'sd0,      1'b1, 1'b0, '0};
        // tie: both terms count fully, p = 1/2
        rows[1]  = '{16'sd0,      1'b0, 1'b1, '{7'd0, 1'b1, 16'd32768, 16'd32768, 7'd1, 1'b0}};
        rows[2]  = '{-16'sd32768, 1'b0, 1'b0, '0};
        // end-of-sequence class wins by the full span: sum stays one, p saturates
        rows[3]  = '{16'sd32767,  1'b0, 1'b1, '{7'd1, 1'b0, 16'd65535, 16'd32768, 7'd1, 1'b1}};
        rows[4]  = '{16'sd5,      1'b0, 1'b0, '0};
        rows[5]  = '{16'sd5,      1'b0, 1'b0, '0};     // swallowed row, closes the sequence
        rows[6]  = '{16'sd32767,  1'b1, 1'b0, '0};
        // loser's exp clamps to zero
        rows[7]  = '{-16'sd32768, 1'b0, 1'b1, '{7'd0, 1'b1, 16'd65535, 16'd65535, 7'd1, 1'b0}};
        rows[8]  = '{16'sd100,    1'b0, 1'b0, '0};
        rows[9]  = '{16'sd100,    1'b1, 1'b0, '0};     // marker mid-row drops the partial row
        rows[10] = '{16'sd1000,   1'b0, 1'b0, '0};
        rows[11] = '{16'sd0,      1'b1, 1'b0, '0};
        rows[12] = '{-16'sd1,     1'b0, 1'b0, '0};
        rows[13] = '{16'sd2,      1'b0, 1'b0, '0};
        rows[14] = '{16'sd2,      1'b0, 1'b0, '0};
        rows[15] = '{-16'sd500,   1'b0, 1'b0, '0};
        rows[16] = '{16'sd3000,   1'b0, 1'b0, '0};

        // out-of-range counts clamp; 128 classes and 64 steps are the extremes
        phases[0] = '{2,   3,   60,  IDLE_NONE};
        phases[1] = '{4,   5,   50,  IDLE_SENDER};
        phases[2] = '{128, 1,   130, IDLE_NONE};
        phases[3] = '{2,   64,  60,  IDLE_RECEIVER};
        phases[4] = '{0,   0,   40,  IDLE_BOTH};
        phases[5] = '{1,   127, 40,  IDLE_RECEIVER};
        phases[6] = '{255, 2,   40,  IDLE_SENDER};

        m_class_pos = 0;
        m_row_max   = 0;
        m_best      = 0;
        m_exp_sum   = 0;
        restart_sequence();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_write(ADDR_CLASSES, 2);
        reg_write(ADDR_STEPS, 3);
        foreach (rows[r]) begin
            it.logit             = rows[r].lg;
            it.first_of_sequence = rows[r].fs;
            send_logit(it, rows[r].typed, rows[r].res);
        end
        drain();

        foreach (phases[p]) begin
            reg_write(ADDR_CLASSES, phases[p].classes);
            reg_write(ADDR_STEPS, phases[p].steps);
            idle_mode = phases[p].mode;
            for (int n = 0; n < phases[p].items; n++) begin
                if (p == 0 && n == 30) begin
                    // hold off until the decoder has handed back every token
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending_tokens.size() != 0) @(posedge i_clk);
                end
                seq_start = (m_class_pos == 0 && m_step_pos == 0);
                it.logit  = random_logit();
                // mostly well-formed sequences, with stray markers as noise
                it.first_of_sequence = seq_start ? ($urandom_range(7) != 0)
                                                 : ($urandom_range(39) == 0);
                send_logit(it, 1'b0, '0);
            end
            drain();
            idle_mode = IDLE_NONE;
        end

        if (mismatches == 0 && pending_tokens.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
